FILE: hw/rtl/cext_pkg.sv
// Shared types and constants for the 32-to-64-bit counter extension block.
`timescale 1ns / 1ps
`default_nettype none
package cext_pkg;

	localparam int COUNTER_SLOTS = 32;
	localparam int SLOT_W        = $clog2(COUNTER_SLOTS);
	localparam int NUM_W         = 8;
	localparam int RAW_W         = 32;
	localparam int EXT_W         = 64;
	localparam int HW_W          = 5;
	localparam int CFG_IDX_W     = 1;
	localparam int CFG_DATA_W    = 5;

	localparam logic [HW_W-1:0]  CYCLE_HW_IDX = 5'd31;
	localparam logic [EXT_W-1:0] ALL_ONES     = '1;

	localparam logic [CFG_IDX_W-1:0] REG_EVENT_COUNT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UNIT_READY  = 1'd1;

	typedef struct packed {
		logic [HW_W-1:0] event_count;
		logic            unit_ready;
	} cfg_t;

endpackage
`default_nettype wire

FILE: hw/rtl/cext_ram.sv
// Synchronous single-write, single-read memory holding the 64-bit counter values.
`timescale 1ns / 1ps
`default_nettype none
module cext_ram
	import cext_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [SLOT_W-1:0] waddr,
	input  wire logic [EXT_W-1:0]  wdata,
	input  wire logic [SLOT_W-1:0] raddr,
	output logic      [EXT_W-1:0]  rdata
);

	logic [EXT_W-1:0] mem_q [COUNTER_SLOTS];
	logic [EXT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

FILE: hw/rtl/cext_cfg.sv
// Configuration registers: event counter count and unit ready.
`timescale 1ns / 1ps
`default_nettype none
module cext_cfg
	import cext_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_EVENT_COUNT: cfg_q.event_count <= cfg_data[HW_W-1:0];
				REG_UNIT_READY:  cfg_q.unit_ready  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

endmodule
`default_nettype wire

FILE: hw/rtl/cext_rmw.sv
// Read-modify-write pipeline with forwarding, entry valid bits and result register.
`timescale 1ns / 1ps
`default_nettype none
module cext_rmw
	import cext_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cfg_t              cfg,
	input  wire logic              accept,
	input  wire logic              action,
	input  wire logic [NUM_W-1:0]  counter_number,
	input  wire logic [RAW_W-1:0]  raw_count,
	input  wire logic              overflow_seen,
	output logic                   ram_we,
	output logic [SLOT_W-1:0]      ram_waddr,
	output logic [EXT_W-1:0]       ram_wdata,
	output logic [SLOT_W-1:0]      ram_raddr,
	input  wire logic [EXT_W-1:0]  ram_rdata,
	output logic                   done,
	output logic [EXT_W-1:0]       extended_value,
	output logic                   result_valid,
	output logic                   clear_overflow,
	output logic [HW_W-1:0]        hardware_index
);

	logic                     ok_0;
	logic [HW_W-1:0]          hw_0;
	logic                     clr_0;

	logic                     vld_s1;
	logic                     ok_s1;
	logic [SLOT_W-1:0]        addr_s1;
	logic [RAW_W-1:0]         raw_s1;
	logic                     ovf_s1;
	logic [HW_W-1:0]          hw_s1;
	logic                     rdv_s1;

	logic [COUNTER_SLOTS-1:0] ent_vld_q;
	logic                     fwd_vld_q;
	logic [SLOT_W-1:0]        fwd_addr_q;
	logic [EXT_W-1:0]         fwd_data_q;

	logic [EXT_W-1:0]         old_val;
	logic [RAW_W-1:0]         upper;
	logic [EXT_W-1:0]         joined;
	logic [EXT_W-1:0]         new_val;

	logic                     done_q;
	logic [EXT_W-1:0]         ext_q;
	logic                     rv_q;
	logic                     clr_q;
	logic [HW_W-1:0]          hw_q;

	assign clr_0 = accept && action;

	always_comb begin
		ok_0 = cfg.unit_ready && !action && (counter_number < NUM_W'(COUNTER_SLOTS)) &&
		       ((counter_number == '0) ||
		        (counter_number <= {{(NUM_W-HW_W){1'b0}}, cfg.event_count}));
		if (counter_number == '0) begin
			hw_0 = CYCLE_HW_IDX;
		end else begin
			hw_0 = HW_W'(counter_number - NUM_W'(1));
		end
	end

	assign ram_raddr = counter_number[SLOT_W-1:0];

	always_comb begin
		if (fwd_vld_q && (fwd_addr_q == addr_s1)) begin
			old_val = fwd_data_q;
		end else if (rdv_s1) begin
			old_val = ram_rdata;
		end else begin
			old_val = '0;
		end
		upper  = old_val[EXT_W-1:RAW_W] + RAW_W'(ovf_s1);
		joined = {upper, raw_s1};
		if (joined < old_val) begin
			new_val = {upper + RAW_W'(1), raw_s1};
		end else begin
			new_val = joined;
		end
	end

	assign ram_we    = vld_s1 && ok_s1;
	assign ram_waddr = addr_s1;
	assign ram_wdata = new_val;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			ok_s1  <= 1'b0;
		end else begin
			vld_s1 <= accept;
			ok_s1  <= accept && ok_0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			addr_s1 <= counter_number[SLOT_W-1:0];
			raw_s1  <= raw_count;
			ovf_s1  <= overflow_seen;
			hw_s1   <= hw_0;
			rdv_s1  <= ent_vld_q[counter_number[SLOT_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (clr_0) begin
			ent_vld_q <= '0;
			fwd_vld_q <= 1'b0;
		end else if (ram_we) begin
			ent_vld_q[addr_s1] <= 1'b1;
			fwd_vld_q          <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ram_we) begin
			fwd_addr_q <= addr_s1;
			fwd_data_q <= new_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			ext_q <= ok_s1 ? new_val : ALL_ONES;
			rv_q  <= ok_s1;
			clr_q <= ok_s1 && ovf_s1;
			hw_q  <= ok_s1 ? hw_s1 : '0;
		end
	end

	assign done           = done_q;
	assign extended_value = ext_q;
	assign result_valid   = rv_q;
	assign clear_overflow = clr_q;
	assign hardware_index = hw_q;

endmodule
`default_nettype wire

FILE: hw/rtl/counter_extend_32_to_64.sv
// Top level of the 32-to-64-bit performance counter extension block.
// Commands pass a stage-1 register, then the result registers driving done and outputs.
// Throughput: one command per cycle; the store is one 32 x 64 memory with one read and one
// write port, and a write-back register forwards the last written value to the next read.
// Reset: arst_n clears the configuration, the pipeline and the per-entry valid bits at once,
// so every stored value reads as zero with no clearing pass; done is never stalled.
`timescale 1ns / 1ps
`default_nettype none
module counter_extend_32_to_64
	import cext_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  action,
	input  wire logic [NUM_W-1:0]      counter_number,
	input  wire logic [RAW_W-1:0]      raw_count,
	input  wire logic                  overflow_seen,
	output logic                       done,
	output logic [EXT_W-1:0]           extended_value,
	output logic                       result_valid,
	output logic                       clear_overflow,
	output logic [HW_W-1:0]            hardware_index,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t              cfg;
	logic              accept;
	logic              ram_we;
	logic [SLOT_W-1:0] ram_waddr;
	logic [EXT_W-1:0]  ram_wdata;
	logic [SLOT_W-1:0] ram_raddr;
	logic [EXT_W-1:0]  ram_rdata;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	cext_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cext_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	cext_rmw u_rmw (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg),
		.accept         (accept),
		.action         (action),
		.counter_number (counter_number),
		.raw_count      (raw_count),
		.overflow_seen  (overflow_seen),
		.ram_we         (ram_we),
		.ram_waddr      (ram_waddr),
		.ram_wdata      (ram_wdata),
		.ram_raddr      (ram_raddr),
		.ram_rdata      (ram_rdata),
		.done           (done),
		.extended_value (extended_value),
		.result_valid   (result_valid),
		.clear_overflow (clear_overflow),
		.hardware_index (hardware_index)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/cext_chk.sv
// Port-level checker for the counter extension block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module cext_chk
	import cext_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             start,
	input wire logic             busy,
	input wire logic             done,
	input wire logic [EXT_W-1:0] extended_value,
	input wire logic             result_valid,
	input wire logic             clear_overflow,
	input wire logic [HW_W-1:0]  hardware_index
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##2 done)
		else $error("accepted command produced no result two cycles later");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching accepted command");

	a_invalid_form: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result_valid) |->
		(extended_value == ALL_ONES) && !clear_overflow && (hardware_index == '0))
		else $error("invalid result not in canonical form");

	a_clear_needs_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(done && clear_overflow) |-> result_valid)
		else $error("overflow clear requested on an invalid result");

endmodule

bind counter_extend_32_to_64 cext_chk u_cext_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.done           (done),
	.extended_value (extended_value),
	.result_valid   (result_valid),
	.clear_overflow (clear_overflow),
	.hardware_index (hardware_index)
);
`default_nettype wire

FILE: sim/counter_extend_32_to_64_test.sv
// Self-checking testbench for the 32-to-64-bit counter extension block.
`timescale 1ns / 1ps
module counter_extend_32_to_64_test;
	import cext_pkg::*;

	localparam logic [EXT_W-1:0] UPPER_STEP = 64'h0000_0001_0000_0000;

	typedef struct packed {
		logic [EXT_W-1:0] value;
		logic             valid;
		logic             clr_ovf;
		logic [HW_W-1:0]  hw_idx;
	} count_result_t;

	class count_scoreboard;
		logic [EXT_W-1:0] running_counts [COUNTER_SLOTS];
		logic [HW_W-1:0]  event_count;
		logic             unit_ready;
		count_result_t    expected_q [$];
		int               mismatches;
		int               results_checked;
		int               valid_samples;
		int               overflow_requests;
		int               clears;

		function new();
			foreach (running_counts[i]) running_counts[i] = '0;
			event_count = '0;
			unit_ready = 1'b0;
			mismatches = 0;
			results_checked = 0;
			valid_samples = 0;
			overflow_requests = 0;
			clears = 0;
		endfunction

		function void write_reg(input logic [CFG_IDX_W-1:0] idx,
				input logic [CFG_DATA_W-1:0] data);
			if (idx == REG_EVENT_COUNT) begin
				event_count = data[HW_W-1:0];
			end else if (idx == REG_UNIT_READY) begin
				unit_ready = data[0];
			end
		endfunction

		function void note_command(input logic act, input logic [NUM_W-1:0] num,
				input logic [RAW_W-1:0] raw, input logic ovf);
			count_result_t    res;
			logic [EXT_W-1:0] prior;
			logic [EXT_W-1:0] extended;
			logic             mapped;
			logic [HW_W-1:0]  hw;
			res = '{value: ALL_ONES, valid: 1'b0, clr_ovf: 1'b0, hw_idx: '0};
			mapped = 1'b0;
			hw = '0;
			if (act) begin
				foreach (running_counts[i]) running_counts[i] = '0;
				clears++;
			end else if (unit_ready && num < COUNTER_SLOTS) begin
				if (num == '0) begin
					mapped = 1'b1;
					hw = CYCLE_HW_IDX;
				end else if (num <= NUM_W'(event_count)) begin
					mapped = 1'b1;
					hw = HW_W'(num - 8'd1);
				end
			end
			if (mapped) begin
				prior = running_counts[num[SLOT_W-1:0]];
				extended = {prior[EXT_W-1:RAW_W], {RAW_W{1'b0}}};
				if (ovf) extended = extended + UPPER_STEP;
				extended[RAW_W-1:0] = raw;
				if (extended < prior) extended = extended + UPPER_STEP;
				running_counts[num[SLOT_W-1:0]] = extended;
				res = '{value: extended, valid: 1'b1, clr_ovf: ovf, hw_idx: hw};
			end
			expected_q.push_back(res);
		endfunction

		function void check_result(input count_result_t got);
			count_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: value %h valid %b clr %b hw %0d",
						got.value, got.valid, got.clr_ovf, got.hw_idx);
				return;
			end
			want = expected_q.pop_front();
			results_checked++;
			if (want.valid) valid_samples++;
			if (want.clr_ovf) overflow_requests++;
			if (got.value !== want.value || got.valid !== want.valid ||
					got.clr_ovf !== want.clr_ovf || got.hw_idx !== want.hw_idx) begin
				mismatches++;
				if (mismatches <= 10)
					$display("mismatch at %0t: value %h/%h valid %b/%b clr %b/%b hw %0d/%0d",
						$time, want.value, got.value, want.valid, got.valid,
						want.clr_ovf, got.clr_ovf, want.hw_idx, got.hw_idx);
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start = 1'b0;
	logic                  busy;
	logic                  action = 1'b0;
	logic [NUM_W-1:0]      counter_number = '0;
	logic [RAW_W-1:0]      raw_count = '0;
	logic                  overflow_seen = 1'b0;
	logic                  done;
	logic [EXT_W-1:0]      extended_value;
	logic                  result_valid;
	logic                  clear_overflow;
	logic [HW_W-1:0]       hardware_index;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	count_scoreboard sb = new();
	int commands_sent = 0;

	counter_extend_32_to_64 dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
			if (start && !busy) sb.note_command(action, counter_number, raw_count, overflow_seen);
			if (done)
				sb.check_result('{value: extended_value, valid: result_valid,
					clr_ovf: clear_overflow, hw_idx: hardware_index});
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50) return 0;
		if (roll < 88) return $urandom_range(1, 3);
		if (roll < 98) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic send_command(input logic act, input logic [NUM_W-1:0] num,
			input logic [RAW_W-1:0] raw, input logic ovf);
		start <= 1'b1;
		action <= act;
		counter_number <= num;
		raw_count <= raw;
		overflow_seen <= ovf;
		do @(posedge clk); while (busy);
		commands_sent++;
	endtask

	task automatic hold_sender(input bit allow_gaps);
		int gap;
		gap = allow_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		@(posedge clk);
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] count_data,
			input logic [CFG_DATA_W-1:0] ready_data);
		cfg_valid <= 1'b1;
		cfg_index <= REG_EVENT_COUNT;
		cfg_data <= count_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_UNIT_READY;
		cfg_data <= ready_data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_random(input int count_limit, input bit allow_gaps);
		int               roll;
		logic             act;
		logic [NUM_W-1:0] num;
		logic [RAW_W-1:0] raw;
		logic             ovf;
		act = ($urandom_range(0, 99) < 3);
		roll = $urandom_range(0, 99);
		if (roll < 78) num = NUM_W'($urandom_range(0, count_limit));
		else if (roll < 88) num = NUM_W'($urandom_range(0, 2));
		else if (roll < 94) num = NUM_W'($urandom_range(count_limit + 1, 31));
		else num = NUM_W'($urandom());
		roll = $urandom_range(0, 99);
		if (roll < 60) raw = $urandom();
		else if (roll < 75) raw = RAW_W'($urandom_range(0, 255));
		else if (roll < 90) raw = ~RAW_W'($urandom_range(0, 255));
		else if (roll < 95) raw = '1;
		else raw = '0;
		ovf = ($urandom_range(0, 99) < 20);
		send_command(act, num, raw, ovf);
		hold_sender(allow_gaps);
	endtask

	initial begin
		logic [CFG_DATA_W-1:0] ready_data;
		logic [CFG_DATA_W-1:0] count_data;
		int                    phase_items;
		bit                    allow_gaps;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_command(1'b0, 8'd0, 32'h1234_5678, 1'b1);
		send_command(1'b0, 8'd3, 32'hffff_ffff, 1'b0);
		send_command(1'b1, 8'd0, 32'h0, 1'b0);
		drain_results();

		configure(5'd31, 5'b00001);
		send_command(1'b0, 8'd0, 32'h0000_0000, 1'b0);
		send_command(1'b0, 8'd0, 32'hffff_ffff, 1'b0);
		send_command(1'b0, 8'd0, 32'h0000_0005, 1'b0);
		send_command(1'b0, 8'd0, 32'h0000_0006, 1'b1);
		send_command(1'b0, 8'd1, 32'hffff_ffff, 1'b1);
		send_command(1'b0, 8'd31, 32'ha5a5_a5a5, 1'b0);
		send_command(1'b0, 8'd32, 32'h5a5a_5a5a, 1'b1);
		send_command(1'b0, 8'd255, 32'hffff_ffff, 1'b1);
		send_command(1'b0, 8'd128, 32'h0000_0001, 1'b0);
		send_command(1'b0, 8'd31, 32'h0000_0000, 1'b1);
		send_command(1'b1, 8'd0, 32'hffff_ffff, 1'b1);
		send_command(1'b0, 8'd0, 32'h0000_0001, 1'b0);
		send_command(1'b0, 8'd31, 32'h0000_0000, 1'b0);
		drain_results();

		configure(5'd0, 5'b11111);
		send_command(1'b0, 8'd0, 32'h8000_0000, 1'b1);
		send_command(1'b0, 8'd1, 32'h0000_0010, 1'b1);
		send_command(1'b0, 8'd31, 32'h0000_0020, 1'b0);
		drain_results();

		configure(5'd7, 5'b11110);
		send_command(1'b0, 8'd0, 32'h0000_0003, 1'b1);
		send_command(1'b0, 8'd2, 32'h0000_0004, 1'b0);
		drain_results();

		for (int phase = 0; phase < 6; phase++) begin
			ready_data = CFG_DATA_W'($urandom());
			ready_data[0] = 1'b1;
			phase_items = 220;
			allow_gaps = 1'b1;
			case (phase)
				0: count_data = 5'd31;
				1: count_data = 5'd1;
				3: begin
					ready_data[0] = 1'b0;
					phase_items = 60;
					count_data = CFG_DATA_W'($urandom());
				end
				4: begin
					count_data = 5'd31;
					allow_gaps = 1'b0;
				end
				default: count_data = CFG_DATA_W'($urandom());
			endcase
			configure(count_data, ready_data);
			for (int n = 0; n < phase_items; n++) begin
				send_random(int'(count_data), allow_gaps);
				if ($urandom_range(0, 199) == 0) drain_results();
			end
			drain_results();
		end

		drain_results();
		repeat (10) @(posedge clk);
		$display("covered %0d commands: %0d results checked, %0d valid samples, %0d clears",
			commands_sent, sb.results_checked, sb.valid_samples, sb.clears);
		$display("%0d overflow clear requests seen, %0d mismatches",
			sb.overflow_requests, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("TB_ERROR");
		$finish;
	end

endmodule
